// File: design/dhcp_rop_pkg.sv
// ----------------------------------------------------------------------------
// dhcp_rop_pkg
// Types, codes and constants shared by the DHCP reply option parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcp_rop_pkg;

  // One input word: a payload byte and its end-of-packet flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  // Reply status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_NOT_REPLY    = 3'd2,
    ST_BAD_COOKIE   = 3'd3,
    ST_XID_MISMATCH = 3'd4
  } status_t;

  // One result word.
  typedef struct packed {
    status_t     status;
    logic [7:0]  dhcp_type;
    logic [31:0] offered_ip;
    logic [31:0] netmask;
    logic [31:0] gateway_ip;
    logic [31:0] dns_ip;
  } out_word_t;

  // Per-byte step that the front end hands to the header and option units.
  typedef struct packed {
    logic       any;   // a byte is consumed this cycle
    logic       hdr;   // byte lies in the fixed header
    logic       opt;   // byte lies in the option area
    logic       last;  // byte closes the packet
    logic [7:0] off;   // header offset (valid when hdr is set)
    logic [7:0] data;
  } step_t;

  // Header unit view after the current byte.
  typedef struct packed {
    status_t     reject;
    logic [31:0] offer;
  } hdr_res_t;

  // Option unit view after the current byte.
  typedef struct packed {
    logic [7:0]  dhcp_type;
    logic [31:0] mask;
    logic [31:0] router;
    logic [31:0] dns;
  } opt_res_t;

  // Register map.
  localparam logic REG_XID = 1'b0;

  // Header layout and values.
  localparam int unsigned HDR_LEN       = 240;
  localparam logic [31:0] COOKIE        = 32'h6382_5363;
  localparam logic [31:0] XID_RESET     = 32'h1337_BEEF;
  localparam logic [7:0]  OP_REPLY      = 8'd2;
  localparam logic [7:0]  OFF_OP        = 8'd0;
  localparam logic [7:0]  OFF_XID_LO    = 8'd4;
  localparam logic [7:0]  OFF_XID_HI    = 8'd7;
  localparam logic [7:0]  OFF_YIADDR_LO = 8'd16;
  localparam logic [7:0]  OFF_YIADDR_HI = 8'd19;
  localparam logic [7:0]  OFF_COOKIE_LO = 8'd236;
  localparam logic [7:0]  OFF_COOKIE_HI = 8'd239;

  // Option codes.
  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_MASK    = 8'd1;
  localparam logic [7:0] OPT_ROUTER  = 8'd3;
  localparam logic [7:0] OPT_DNS     = 8'd6;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_END     = 8'd255;

  // Byte idx of a big-endian word, 0 being the most significant.
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      2'd3: b = w[7:0];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: design/dhcp_rop_hdr.sv
// ----------------------------------------------------------------------------
// dhcp_rop_hdr
// Fixed-header checks (op, xid, cookie) and your-address capture.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_rop_hdr (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dhcp_rop_pkg::step_t    step,
  input  wire logic [31:0]           xid,
  output dhcp_rop_pkg::hdr_res_t     res
);
  import dhcp_rop_pkg::*;

  status_t     reject_r, reject_nxt;
  logic [31:0] offer_r, offer_nxt;
  logic [7:0]  want_xid;
  logic [7:0]  want_cookie;

  assign want_xid    = be_byte(xid, step.off[1:0]);
  assign want_cookie = be_byte(COOKIE, step.off[1:0]);

  always_comb begin
    reject_nxt = reject_r;
    offer_nxt  = offer_r;
    if (step.hdr) begin
      if (step.off == OFF_OP) begin
        if (step.data != OP_REPLY) begin
          reject_nxt = ST_NOT_REPLY;
        end
      end else if (step.off >= OFF_XID_LO && step.off <= OFF_XID_HI) begin
        if (step.data != want_xid && reject_r == ST_OK) begin
          reject_nxt = ST_XID_MISMATCH;
        end
      end else if (step.off >= OFF_YIADDR_LO && step.off <= OFF_YIADDR_HI) begin
        offer_nxt = {offer_r[23:0], step.data};
      end else if (step.off >= OFF_COOKIE_LO && step.off <= OFF_COOKIE_HI) begin
        // cookie fault outranks an xid fault but not a wrong op
        if (step.data != want_cookie &&
            (reject_r == ST_OK || reject_r == ST_XID_MISMATCH)) begin
          reject_nxt = ST_BAD_COOKIE;
        end
      end
    end
  end

  assign res.reject = reject_nxt;
  assign res.offer  = offer_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step.any && step.last)) begin
      reject_r <= ST_OK;
      offer_r  <= '0;
    end else begin
      reject_r <= reject_nxt;
      offer_r  <= offer_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/dhcp_rop_opt.sv
// ----------------------------------------------------------------------------
// dhcp_rop_opt
// Option TLV walker: skip pads, stop at end, capture selected options.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_rop_opt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dhcp_rop_pkg::step_t    step,
  output dhcp_rop_pkg::opt_res_t     res
);
  import dhcp_rop_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_VAL  = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic        ended_r, ended_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [31:0] router_r, router_nxt;
  logic [31:0] dns_r, dns_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    shift_nxt  = shift_r;
    ended_nxt  = ended_r;
    type_nxt   = type_r;
    mask_nxt   = mask_r;
    router_nxt = router_r;
    dns_nxt    = dns_r;
    if (step.opt && !ended_r) begin
      unique case (phase_r)
        PH_TYPE: begin
          if (step.data == OPT_END) begin
            ended_nxt = 1'b1;
          end else if (step.data != OPT_PAD) begin
            code_nxt  = step.data;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          len_nxt   = step.data;
          idx_nxt   = '0;
          shift_nxt = '0;
          phase_nxt = (step.data == 8'd0) ? PH_TYPE : PH_VAL;
        end
        PH_VAL: begin
          // keep only the first four value bytes
          if (idx_r < 8'd4) begin
            shift_nxt = {shift_r[23:0], step.data};
          end
          idx_nxt = idx_r + 8'd1;
          if (idx_nxt >= len_r) begin
            phase_nxt = PH_TYPE;
            priority if (code_r == OPT_MSGTYPE && len_r == 8'd1) begin
              type_nxt = shift_nxt[7:0];
            end else if (code_r == OPT_MASK && len_r == 8'd4) begin
              mask_nxt = shift_nxt;
            end else if (code_r == OPT_ROUTER && len_r >= 8'd4) begin
              router_nxt = shift_nxt;
            end else if (code_r == OPT_DNS && len_r >= 8'd4) begin
              dns_nxt = shift_nxt;
            end
          end
        end
        default: phase_nxt = PH_TYPE;
      endcase
    end
  end

  assign res.dhcp_type = type_nxt;
  assign res.mask      = mask_nxt;
  assign res.router    = router_nxt;
  assign res.dns       = dns_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step.any && step.last)) begin
      phase_r  <= PH_TYPE;
      code_r   <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      shift_r  <= '0;
      ended_r  <= 1'b0;
      type_r   <= '0;
      mask_r   <= '0;
      router_r <= '0;
      dns_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      code_r   <= code_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      shift_r  <= shift_nxt;
      ended_r  <= ended_nxt;
      type_r   <= type_nxt;
      mask_r   <= mask_nxt;
      router_r <= router_nxt;
      dns_r    <= dns_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/dhcp_reply_option_parser.sv
// ----------------------------------------------------------------------------
// dhcp_reply_option_parser
// Byte-stream DHCP reply parser with header checks and option capture.
// ----------------------------------------------------------------------------
// Feed the UDP payload of a DHCP reply one byte per word on the input
// channel, with last set on the final byte. The block takes one byte every
// cycle unless out_stall holds it; each byte passes an input register and
// then an update of the header and option state, and the result word for a
// packet is registered as its last byte leaves the input register, so the
// next packet may follow at once. While a result word waits under out_stall
// the parse stage holds, and in_stall rises once the input register is full too.
// The header checks report, by priority: too short (under 240 bytes), not a
// reply, bad magic cookie, transaction id unlike the expected_xid register
// (byte address 0). On any fault every field but status reads zero. Bytes past
// MAX_PAYLOAD are dropped, though last still closes the packet. Write
// expected_xid only between packets.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_reply_option_parser #(
  parameter int unsigned MAX_PAYLOAD = 2047
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // byte input
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire dhcp_rop_pkg::in_word_t   in_data,
  // result output
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output dhcp_rop_pkg::out_word_t       out_data,
  // register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dhcp_rop_pkg::*;

  // offset counter must hold MAX_PAYLOAD itself
  localparam int unsigned OFS_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_PAYLOAD);
  localparam logic [OFS_W-1:0] HDR_OFS = OFS_W'(HDR_LEN);

  logic [31:0]      xid_r;
  logic             s1_valid_r;
  in_word_t         s1_word_r;
  logic             out_valid_r;
  out_word_t        out_word_r;
  logic [OFS_W-1:0] ofs_r, ofs_nxt, ofs_inc;
  logic             advance;
  logic             counting;
  logic             in_hdr;
  logic             too_short;
  step_t            step;
  hdr_res_t         hdr_res;
  opt_res_t         opt_res;
  out_word_t        result;

  // ---- register port -------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_XID) ? xid_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xid_r <= XID_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_XID) begin
      xid_r <= pwdata;
    end
  end

  // ---- input register ------------------------------------------------------
  // The parse stage advances unless a finished result is stuck at the output.
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r <= in_data;
    end
  end

  // ---- byte offset and step decode ----------------------------------------
  assign counting  = ofs_r < MAX_OFS;
  assign in_hdr    = ofs_r < HDR_OFS;
  assign ofs_inc   = ofs_r + OFS_W'(counting);
  assign too_short = ofs_inc < HDR_OFS;

  assign step.any  = s1_valid_r && advance;
  assign step.hdr  = step.any && counting && in_hdr;
  assign step.opt  = step.any && counting && !in_hdr;
  assign step.last = s1_word_r.last;
  assign step.off  = ofs_r[7:0];
  assign step.data = s1_word_r.data_byte;

  always_comb begin
    ofs_nxt = ofs_r;
    if (step.any) begin
      ofs_nxt = step.last ? '0 : ofs_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= '0;
    end else begin
      ofs_r <= ofs_nxt;
    end
  end

  // ---- header and option units --------------------------------------------
  dhcp_rop_hdr u_hdr (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .xid   (xid_r),
    .res   (hdr_res)
  );

  dhcp_rop_opt u_opt (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (opt_res)
  );

  // ---- result assembly and output register --------------------------------
  always_comb begin
    result.status     = too_short ? ST_SHORT : hdr_res.reject;
    result.dhcp_type  = '0;
    result.offered_ip = '0;
    result.netmask    = '0;
    result.gateway_ip = '0;
    result.dns_ip     = '0;
    // zero every captured field on a rejected packet
    if (result.status == ST_OK) begin
      result.dhcp_type  = opt_res.dhcp_type;
      result.offered_ip = hdr_res.offer;
      result.netmask    = opt_res.mask;
      result.gateway_ip = opt_res.router;
      result.dns_ip     = opt_res.dns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.any && step.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.any && step.last) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // ---- assertions ----------------------------------------------------------
  a_ofs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ofs_r <= MAX_OFS)
    else $error("byte offset ran past MAX_PAYLOAD");

  a_ofs_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step.any && step.last) |=> (ofs_r == '0))
    else $error("byte offset not cleared after closing byte");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_OK) |->
      (out_word_r.dhcp_type == '0 && out_word_r.offered_ip == '0 &&
       out_word_r.netmask == '0 && out_word_r.gateway_ip == '0 &&
       out_word_r.dns_ip == '0))
    else $error("rejected packet carries captured fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.status <= ST_XID_MISMATCH))
    else $error("status code out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !step.any)
    else $error("parse stage advanced while result is held");

endmodule

`default_nettype wire
